// ----- rtl/sar_pkg.sv -----
package sar_pkg;

  typedef logic [3:0] op_t;

  localparam op_t OP_CTRL    = 4'd0;
  localparam op_t OP_SCROLL  = 4'd1;
  localparam op_t OP_ADDR    = 4'd2;
  localparam op_t OP_DATA    = 4'd3;
  localparam op_t OP_STATUS  = 4'd4;
  localparam op_t OP_INC_X   = 4'd5;
  localparam op_t OP_INC_Y   = 4'd6;
  localparam op_t OP_COPY_H  = 4'd7;
  localparam op_t OP_COPY_V  = 4'd8;

  localparam int AddrW = 15;

  // Coarse Y row at which the vertical nametable flips.
  localparam logic [4:0] LAST_ROW = 5'd29;

  // Address layout: fine Y 14..12, nametable 11..10, coarse Y 9..5, coarse X 4..0.
  typedef struct packed {
    logic [AddrW-1:0] video;
    logic [AddrW-1:0] temp;
    logic [2:0]       fine_x;
    logic             toggle;
    logic             step32;
  } sar_state_t;

endpackage

// ----- rtl/scroll_address_registers.sv -----
// Scroll and video address registers of a tile-based picture unit.
//
// Input channel (s_axis): one event per item. tuser carries the event code
// (control, scroll and address writes, data access, status read, coarse X
// step, Y step, horizontal and vertical copy); tdata carries the written byte.
// Output channel (m_axis): exactly one result item per event, giving the
// address before the event (low 14 bits) and the video address, temporary
// address, fine X and write toggle after it.
//
// An event passes an input register, then the update logic, which writes the
// state and the result register. One item is taken every cycle; the update
// logic is a single pass, so nothing limits the rate but the output handshake.
// Reset clears all address state, the toggle and the step mode, and empties
// both register stages. When the receiver stalls, the result holds, the
// input register fills, and s_axis_tready falls until the result is taken.
module scroll_address_registers (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // value[7:0]
  input  logic [3:0]  s_axis_tuser,   // op[3:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // access_addr[13:0], vram_addr[28:14], temp_addr[43:29],
  // fine_x_out[46:44], toggle_out[47]
  output logic [47:0] m_axis_tdata
);
  import sar_pkg::*;

  logic       in_valid;
  op_t        in_op;
  logic [7:0] in_value;
  logic       out_valid;
  logic [47:0] out_data;
  sar_state_t st;
  sar_state_t st_next;
  logic [13:0] access_addr;
  logic       out_load;
  logic       advance;

  assign out_load      = !out_valid || m_axis_tready;
  assign advance       = in_valid && out_load;
  assign s_axis_tready = !in_valid || out_load;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  sar_step u_step (
    .cur         (st),
    .op          (in_op),
    .value       (in_value),
    .nxt         (st_next),
    .access_addr (access_addr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= '0;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (out_load) out_valid <= in_valid;
      if (advance) st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op    <= s_axis_tuser;
      in_value <= s_axis_tdata;
    end
    if (advance) begin
      out_data <= {st_next.toggle, st_next.fine_x, st_next.temp, st_next.video, access_addr};
    end
  end

endmodule

// ----- rtl/sar_step.sv -----
module sar_step (
  input  sar_pkg::sar_state_t cur,
  input  sar_pkg::op_t        op,
  input  logic [7:0]          value,
  output sar_pkg::sar_state_t nxt,
  output logic [13:0]         access_addr
);
  import sar_pkg::*;

  logic [AddrW-1:0] v;
  logic [AddrW-1:0] t;
  logic [4:0]       coarse_y;

  assign access_addr = cur.video[13:0];
  assign v           = cur.video;
  assign t           = cur.temp;
  assign coarse_y    = v[9:5];

  always_comb begin
    nxt = cur;
    case (op)
      OP_CTRL: begin
        nxt.temp   = {t[14:12], value[1:0], t[9:0]};
        nxt.step32 = value[2];
      end
      OP_SCROLL: begin
        if (!cur.toggle) begin
          nxt.temp   = {t[14:5], value[7:3]};
          nxt.fine_x = value[2:0];
          nxt.toggle = 1'b1;
        end else begin
          nxt.temp   = {value[2:0], t[11:10], value[7:3], t[4:0]};
          nxt.toggle = 1'b0;
        end
      end
      OP_ADDR: begin
        if (!cur.toggle) begin
          nxt.temp   = {1'b0, value[5:0], t[7:0]};
          nxt.toggle = 1'b1;
        end else begin
          nxt.temp   = {t[14:8], value};
          nxt.video  = {t[14:8], value};
          nxt.toggle = 1'b0;
        end
      end
      OP_DATA: begin
        nxt.video = v + (cur.step32 ? AddrW'(32) : AddrW'(1));
      end
      OP_STATUS: begin
        nxt.toggle = 1'b0;
      end
      OP_INC_X: begin
        if (&v[4:0]) begin
          nxt.video = {v[14:11], ~v[10], v[9:5], 5'd0};
        end else begin
          nxt.video = {v[14:5], v[4:0] + 5'd1};
        end
      end
      OP_INC_Y: begin
        if (!(&v[14:12])) begin
          nxt.video = {v[14:12] + 3'd1, v[11:0]};
        end else if (coarse_y == LAST_ROW) begin
          nxt.video = {3'd0, ~v[11], v[10], 5'd0, v[4:0]};
        end else if (&coarse_y) begin
          // Coarse Y 31, past the visible area, wraps to 0 without the nametable flip.
          nxt.video = {3'd0, v[11:10], 5'd0, v[4:0]};
        end else begin
          nxt.video = {3'd0, v[11:10], coarse_y + 5'd1, v[4:0]};
        end
      end
      OP_COPY_H: begin
        nxt.video = {v[14:11], t[10], v[9:5], t[4:0]};
      end
      OP_COPY_V: begin
        nxt.video = {t[14:11], v[10], t[9:5], v[4:0]};
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// ----- rtl/sar_checker.sv -----
module sar_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);
  logic        in_acc;
  logic        out_acc;
  logic [1:0]  pending;
  logic [14:0] last_vram;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Items in flight and the video address reported by the last result.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 2'd0;
      last_vram <= 15'd0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc) last_vram <= m_axis_tdata[28:14];
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pending != 2'd0)
    else $error("result without a pending item");

  a_bounded: assert property (@(posedge clk) disable iff (rst) pending != 2'd3)
    else $error("more items in flight than register stages");

  a_chain: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> m_axis_tdata[13:0] == last_vram[13:0])
    else $error("access address does not follow previous video address");

endmodule

bind scroll_address_registers sar_checker u_sar_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
